[rtl/core/pgr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgr_pkg: shared types and constants of the palette gray remap
// Palette geometry, queue sizing, luminance constants and the command and
// status structs passed between front, queue and back.
// ----------------------------------------------------------------------------
package pgr_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
    localparam logic [7:0] PAL_LAST = 8'(PALETTE_ENTRIES - 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // luma = floor((300r + 590g + 110b) / 1000)
    localparam int LUMA_SUM_W = 18;
    localparam logic [9:0] LUMA_R = 10'd300;
    localparam logic [9:0] LUMA_G = 10'd590;
    localparam logic [9:0] LUMA_B = 10'd110;
    // ceil(2^28 / 1000); exact floor for every sum up to 255000
    localparam int LUMA_RECIP_W = 19;
    localparam logic [LUMA_RECIP_W-1:0] LUMA_RECIP = 19'd268436;
    localparam int LUMA_SHIFT  = 28;
    localparam int LUMA_PROD_W = LUMA_SUM_W + LUMA_RECIP_W;

    localparam logic [8:0] DIST_INIT = 9'd256;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_GRAY_FIRST = 2'd0;
    localparam logic [1:0] REG_GRAY_LAST  = 2'd1;
    localparam logic [1:0] REG_KEEP_BELOW = 2'd2;

    localparam logic [7:0] GRAY_LAST_RST = 8'd255;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_PASS  = 2'd1,
        K_ZERO  = 2'd2,
        K_MAP   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  idx;
        logic [23:0] rgb;
    } t_cmd;

    typedef struct packed {
        logic [7:0] gray_first;
        logic [7:0] gray_last;
        logic [8:0] keep_below;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic pop;
    } t_back_stat;

endpackage

[rtl/core/pgr_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgr_front: input acceptance, classification and config registers
// Takes stream transactions, sorts them into palette writes, pass-through,
// zero results and mapping jobs, and pushes them into the command queue.
// ----------------------------------------------------------------------------
module pgr_front
    import pgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // color_index, red, green, blue
    input  logic        i_s_tuser,   // func
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_cmd        o_cmd,
    output t_cfg        o_cfg
);

    t_cfg        r_cfg;
    logic        cfg_we;
    logic [7:0]  idx;
    logic        in_range;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gray_first <= '0;
            r_cfg.gray_last  <= GRAY_LAST_RST;
            r_cfg.keep_below <= '0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_GRAY_FIRST: r_cfg.gray_first <= pwdata[7:0];
                REG_GRAY_LAST:  r_cfg.gray_last  <= pwdata[7:0];
                REG_KEEP_BELOW: r_cfg.keep_below <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GRAY_FIRST: prdata = {24'd0, r_cfg.gray_first};
            REG_GRAY_LAST:  prdata = {24'd0, r_cfg.gray_last};
            REG_KEEP_BELOW: prdata = {23'd0, r_cfg.keep_below};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

    assign idx      = i_s_tdata[7:0];
    assign in_range = {1'b0, idx} < 9'(PALETTE_ENTRIES);

    assign o_s_tready = !i_q_stat.full;

    always_comb begin
        o_cmd.idx = idx;
        o_cmd.rgb = {i_s_tdata[15:8], i_s_tdata[23:16], i_s_tdata[31:24]};
        if (!i_s_tuser)
            o_cmd.kind = K_WRITE;
        else if (!in_range)
            o_cmd.kind = K_ZERO;
        else if ({1'b0, idx} < r_cfg.keep_below)
            o_cmd.kind = K_PASS;
        else
            o_cmd.kind = K_MAP;
    end

    // writes beyond the palette are dropped here
    assign o_push = i_s_tvalid && o_s_tready && (i_s_tuser || in_range);

endmodule

[rtl/core/pgr_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgr_queue: short command FIFO between front and back
// Register-based FIFO of classified commands; head is shown combinationally.
// ----------------------------------------------------------------------------
module pgr_queue
    import pgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_cmd,
    input  t_back_stat i_back_stat,
    output t_cmd       o_head,
    output t_q_stat    o_stat
);

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push = i_push && !o_stat.full;
    assign do_pop  = i_back_stat.pop && !o_stat.empty;
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_slot[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push)
                r_wptr <= r_wptr + 1'b1;
            if (do_pop)
                r_rptr <= r_rptr + 1'b1;
            if (do_push && !do_pop)
                r_count <= r_count + 1'b1;
            else if (do_pop && !do_push)
                r_count <= r_count - 1'b1;
        end
    end

endmodule

[rtl/core/pgr_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgr_back: palette store, luminance and gray ramp search
// Executes queued commands: palette writes, direct results, and the
// luminance plus nearest-red scan over the gray ramp, one entry per cycle.
// ----------------------------------------------------------------------------
module pgr_back
    import pgr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_head,
    input  t_q_stat    i_q_stat,
    output t_back_stat o_stat,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LUMA = 4'b0010,
        S_DIV  = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [23:0]           r_mem [PALETTE_ENTRIES];
    logic                  r_valid [PALETTE_ENTRIES];
    logic [23:0]           r_rd_data;
    logic                  r_rd_vld;
    logic [PAL_AW-1:0]     raddr;
    logic                  mem_we;
    logic                  pop;

    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_data, n_out_data;
    logic [LUMA_SUM_W-1:0] r_sum, n_sum;
    logic [7:0]            r_ref, n_ref;
    logic [8:0]            r_best_dist, n_best_dist;
    logic [7:0]            r_best, n_best;
    logic [7:0]            r_issue_idx, n_issue_idx;
    logic                  r_issue_on, n_issue_on;
    logic [7:0]            r_cmp_idx, n_cmp_idx;
    logic                  r_cmp_on, n_cmp_on;

    logic [23:0]           entry;
    logic [7:0]            red;
    logic [7:0]            red_gap;
    logic [7:0]            ramp_last;
    logic                  ramp_empty;
    logic                  out_free;
    logic [LUMA_PROD_W-1:0] prod;
    logic                  far;
    logic                  closer;
    logic                  at_end;

    // palette payload
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[i_head.idx[PAL_AW-1:0]] <= i_head.rgb;
        r_rd_data <= r_mem[raddr];
        r_rd_vld  <= r_valid[raddr];
    end

    // never-written entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PALETTE_ENTRIES; k++)
                r_valid[k] <= 1'b0;
        end else if (mem_we) begin
            r_valid[i_head.idx[PAL_AW-1:0]] <= 1'b1;
        end
    end

    assign entry      = r_rd_vld ? r_rd_data : 24'd0;
    assign red        = entry[23:16];
    assign red_gap    = (red >= r_ref) ? (red - r_ref) : (r_ref - red);
    assign ramp_last  = (i_cfg.gray_last > PAL_LAST) ? PAL_LAST : i_cfg.gray_last;
    assign ramp_empty = i_cfg.gray_first > ramp_last;
    assign out_free   = !r_out_valid || i_m_tready;
    assign prod       = LUMA_PROD_W'(r_sum) * LUMA_PROD_W'(LUMA_RECIP);

    assign far    = r_cmp_on && ({1'b0, red_gap} > r_best_dist);
    assign closer = r_cmp_on && ({1'b0, red_gap} < r_best_dist);
    assign at_end = r_cmp_on && (r_cmp_idx == ramp_last);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_sum       = r_sum;
        n_ref       = r_ref;
        n_best_dist = r_best_dist;
        n_best      = r_best;
        n_issue_idx = r_issue_idx;
        n_issue_on  = r_issue_on;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_on    = r_cmp_on;
        pop         = 1'b0;
        mem_we      = 1'b0;
        raddr       = r_issue_idx[PAL_AW-1:0];

        if (r_out_valid && i_m_tready)
            n_out_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                raddr = i_head.idx[PAL_AW-1:0];
                if (!i_q_stat.empty) begin
                    unique case (i_head.kind)
                        K_WRITE: begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        K_PASS: begin
                            if (out_free) begin
                                pop         = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = i_head.idx;
                            end
                        end
                        K_ZERO: begin
                            if (out_free) begin
                                pop         = 1'b1;
                                n_out_valid = 1'b1;
                                n_out_data  = '0;
                            end
                        end
                        K_MAP: begin
                            // output stays free until the scan ends
                            if (out_free) begin
                                pop     = 1'b1;
                                n_state = S_LUMA;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LUMA: begin
                n_sum = LUMA_SUM_W'(entry[23:16]) * LUMA_SUM_W'(LUMA_R)
                      + LUMA_SUM_W'(entry[15:8])  * LUMA_SUM_W'(LUMA_G)
                      + LUMA_SUM_W'(entry[7:0])   * LUMA_SUM_W'(LUMA_B);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_ref = prod[LUMA_SHIFT +: 8];
                if (ramp_empty) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_state     = S_IDLE;
                end else begin
                    n_issue_idx = i_cfg.gray_first;
                    n_issue_on  = 1'b1;
                    n_cmp_on    = 1'b0;
                    n_best_dist = DIST_INIT;
                    n_best      = '0;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                // read of entry n overlaps compare of entry n-1
                if (r_issue_on) begin
                    n_cmp_on  = 1'b1;
                    n_cmp_idx = r_issue_idx;
                    if (r_issue_idx == ramp_last)
                        n_issue_on = 1'b0;
                    else
                        n_issue_idx = r_issue_idx + 1'b1;
                end else begin
                    n_cmp_on = 1'b0;
                end
                if (closer) begin
                    n_best_dist = {1'b0, red_gap};
                    n_best      = r_cmp_idx;
                end
                if (far || at_end) begin
                    n_out_valid = 1'b1;
                    n_out_data  = far ? r_best : n_best;
                    n_issue_on  = 1'b0;
                    n_cmp_on    = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_issue_on  <= 1'b0;
            r_cmp_on    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_issue_on  <= n_issue_on;
            r_cmp_on    <= n_cmp_on;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_sum       <= n_sum;
        r_ref       <= n_ref;
        r_best_dist <= n_best_dist;
        r_best      <= n_best;
        r_issue_idx <= n_issue_idx;
        r_cmp_idx   <= n_cmp_idx;
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.pop  = pop;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

endmodule

[rtl/core/palette_grayscale_remap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_grayscale_remap: maps palette indices onto a gray ramp
// Keeps a 256-entry RGB palette and returns, per pixel index, the ramp entry
// whose red component is nearest the pixel's luminance.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: tuser = func (0 palette write, 1 pixel), tdata = color_index,
//   red, green, blue. Writes give no output transaction; pixels give one
//   m_axis transaction carrying the gray index.
//   APB: gray_first at 0x0, gray_last at 0x4, keep_below at 0x8; write only
//   while no transaction is in flight. pready is tied high.
//   The front takes one transaction per cycle while the 2-deep command queue
//   has room. In the back a palette write, a pass-through or an out-of-range
//   pixel is handled directly in the idle state; a mapped pixel passes through
//   the luminance, divide and scan states; the scan visits ramp entries up to
//   gray_last or until the red distance grows, one entry a cycle, set by the
//   single palette read port. Reset clears the queue, the output register
//   and the palette (per-entry valid bits, no clearing pass) and resets the
//   configuration (gray_last to 255, the others to 0). If m_axis stalls,
//   the result is held, the back keeps doing palette writes, and s_axis
//   stalls once the queue fills.
// ----------------------------------------------------------------------------
module palette_grayscale_remap
    import pgr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] color_index, [15:8] red,
                                        // [23:16] green, [31:24] blue
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] gray_index
);

    t_cfg       cfg;
    t_cmd       push_cmd;
    t_cmd       head;
    logic       push;
    t_q_stat    q_stat;
    t_back_stat back_stat;

    pgr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser[0]),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_cfg      (cfg)
    );

    pgr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (push_cmd),
        .i_back_stat (back_stat),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    pgr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head),
        .i_q_stat   (q_stat),
        .o_stat     (back_stat),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_queue_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.pop |-> !q_stat.empty)
        else $error("back popped an empty queue");

    a_busy_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(back_stat.busy) |-> $past(back_stat.pop))
        else $error("back started work without a command");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
